// ===== rtl/cc32fz_pkg.sv =====
// ----------------------------------------------------------------------------
// cc32fz_pkg
// Shared constants for the CRC-32 checker with a zeroed stored-CRC field.
// ----------------------------------------------------------------------------
package cc32fz_pkg;

  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

  // first byte of the stored-CRC field; the field is four bytes long
  localparam int CRC_FIELD_OFFSET = 12;
  localparam int CRC_FIELD_LEN    = 4;
  localparam int POS_LIMIT = (CRC_FIELD_OFFSET + CRC_FIELD_LEN > 16) ?
                             (CRC_FIELD_OFFSET + CRC_FIELD_LEN) : 16;
  localparam int POS_W = $clog2(POS_LIMIT + 1);

  localparam int ADDR_W = 3;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_EXPECTED_CRC = 1'b0,
    REG_NONE         = 1'b1
  } reg_idx_t;

  typedef logic [POS_W-1:0] pos_t;

endpackage

// ===== rtl/cc32fz_crc_step.sv =====
// ----------------------------------------------------------------------------
// cc32fz_crc_step
// One byte of reflected CRC-32 update, with the stored-CRC window zeroed,
// and the saturating byte position.
// ----------------------------------------------------------------------------
module cc32fz_crc_step
  import cc32fz_pkg::*;
(
  input  logic [31:0] crc,
  input  logic [7:0]  data_byte,
  input  pos_t        pos,
  output logic [31:0] crc_next,
  output pos_t        pos_next
);

  logic        in_window;
  logic [7:0]  byte_eff;
  logic [31:0] c;

  assign in_window = (pos >= pos_t'(CRC_FIELD_OFFSET)) &&
                     (pos <  pos_t'(CRC_FIELD_OFFSET + CRC_FIELD_LEN));
  assign byte_eff  = in_window ? 8'h00 : data_byte;

  always_comb begin
    c = crc ^ {24'h0, byte_eff};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    crc_next = c;
  end

  assign pos_next = (pos < pos_t'(POS_LIMIT)) ? pos + pos_t'(1) : pos;

endmodule

// ===== rtl/cc32fz_regs.sv =====
// ----------------------------------------------------------------------------
// cc32fz_regs
// APB register file: holds the expected CRC.
// ----------------------------------------------------------------------------
module cc32fz_regs
  import cc32fz_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [31:0]       expected_crc
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_crc <= '0;
    end else if (psel && penable && pwrite && pready && idx == REG_EXPECTED_CRC) begin
      expected_crc <= pwdata;
    end
  end

  always_comb begin
    case (idx)
      REG_EXPECTED_CRC: prdata = expected_crc;
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== rtl/container_crc32_field_zeroed_check.sv =====
// ----------------------------------------------------------------------------
// container_crc32_field_zeroed_check
// Running CRC-32 over a byte stream, stored-CRC field read as zero; gives the
// final CRC and a match flag on the last byte of each file.
//
//   channel | dir | handshake         | payload
//   s_*     | in  | tvalid/tready     | tdata = data_byte, tlast = last
//   m_*     | out | tvalid/tready     | tdata = computed_crc, tuser = crc_match
//   apb     | in  | psel/penable      | expected_crc at address 0
//
// One item per cycle while the result is not stalled; an item passes an input
// register, then the CRC update into the running CRC and result register.
// Reset (rst, synchronous) presets the CRC to all ones and clears position.
// A stalled result holds both stages; s_tready follows the output register.
// ----------------------------------------------------------------------------
module container_crc32_field_zeroed_check
  import cc32fz_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] data_byte
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // [31:0] computed_crc
  output logic              m_tuser,   // [0] crc_match
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] expected_crc;
  logic        adv;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic [31:0] running_crc;
  pos_t        byte_position;
  logic [31:0] crc_next;
  pos_t        pos_next;
  logic [31:0] final_crc;

  cc32fz_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .expected_crc (expected_crc)
  );

  cc32fz_crc_step u_step (
    .crc       (running_crc),
    .data_byte (in_byte),
    .pos       (byte_position),
    .crc_next  (crc_next),
    .pos_next  (pos_next)
  );

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign final_crc = ~crc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
      running_crc   <= CRC_PRESET;
      byte_position <= '0;
    end else if (adv) begin
      in_valid <= s_tvalid;
      m_tvalid <= in_valid && in_last;
      if (in_valid) begin
        if (in_last) begin
          running_crc   <= CRC_PRESET;
          byte_position <= '0;
        end else begin
          running_crc   <= crc_next;
          byte_position <= pos_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
      if (in_valid && in_last) begin
        m_tdata <= final_crc;
        m_tuser <= (expected_crc == 32'h0) || (expected_crc == final_crc);
      end
    end
  end

endmodule

// ===== rtl/cc32fz_checker.sv =====
// ----------------------------------------------------------------------------
// cc32fz_checker
// Port-level assertions for the CRC-32 checker, bound to the top level.
// ----------------------------------------------------------------------------
module cc32fz_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not track output register");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
    else $error("result without a last item two cycles earlier");

endmodule

bind container_crc32_field_zeroed_check cc32fz_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/crc32_zero_field_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_zero_field_checker
// Watches the byte stream, the result stream and the register port of the
// CRC-32 checker. Keeps its own running CRC, byte position and expected-CRC
// register, queues the CRC and match flag due on every last byte, and
// compares each accepted result against the oldest queued one.
// ----------------------------------------------------------------------------
module crc32_zero_field_checker
  import cc32fz_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] data_byte
  input  logic              s_tlast,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [31:0]       m_tdata,   // [31:0] computed_crc
  input  logic              m_tuser,   // [0] crc_match
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending_results,
  output logic [31:0]       last_file_crc
);

  typedef struct packed {
    logic [31:0] crc;
    logic        match;
  } crc_result_t;

  crc_result_t result_q[$];
  logic [31:0] run_crc;
  logic [31:0] exp_crc;
  pos_t        byte_pos;

  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  always @(posedge clk) begin
    crc_result_t want;
    logic [7:0]  b;
    logic [31:0] fin;
    int          errs;
    errs = 0;
    if (rst) begin
      run_crc = CRC_PRESET;
      byte_pos = '0;
      exp_crc = '0;
      result_q.delete();
      fail_count <= 0;
      last_file_crc <= '0;
    end else begin
      if (psel && penable && pwrite && pready &&
          reg_idx_t'(paddr[2]) == REG_EXPECTED_CRC) begin
        exp_crc = pwdata;
      end
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result item: computed_crc %h crc_match %b", m_tdata, m_tuser);
          errs++;
        end else begin
          want = result_q.pop_front();
          if (m_tdata !== want.crc) begin
            $error("computed_crc mismatch: expected %h, actual %h", want.crc, m_tdata);
            errs++;
          end
          if (m_tuser !== want.match) begin
            $error("crc_match mismatch: expected %b, actual %b", want.match, m_tuser);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        // stored-CRC field bytes count as zero
        b = (byte_pos >= CRC_FIELD_OFFSET && byte_pos < CRC_FIELD_OFFSET + CRC_FIELD_LEN) ?
            8'h00 : s_tdata;
        run_crc = crc_update(run_crc, b);
        if (byte_pos < POS_LIMIT) byte_pos++;
        if (s_tlast) begin
          fin = ~run_crc;
          want.crc = fin;
          want.match = (exp_crc == 32'h0) || (exp_crc == fin);
          result_q.push_back(want);
          last_file_crc <= fin;
          run_crc = CRC_PRESET;
          byte_pos = '0;
        end
      end
      fail_count <= fail_count + errs;
    end
    pending_results <= result_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the CRC-32 checker with a zeroed stored-CRC field.
// Sends directed files (single bytes, extreme values, a file past the
// position limit) and then random files under changing expected-CRC settings,
// including replays whose CRC field bytes differ but must still match.
// Both stream sides idle in random bursts; the run's tail is idle-free.
// ----------------------------------------------------------------------------
module tb;
  import cc32fz_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1650;
  localparam int QUIET_TAIL   = 200;
  localparam int DRAIN_CYCLES = 8;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = '0;
  logic              s_tlast  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;
  logic              m_tuser;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;

  int          fail_count;
  int          pending_results;
  logic [31:0] last_file_crc;

  bit         idle_on = 1'b1;
  int         items_sent;
  int         cycle_count;
  int         stall_left;
  logic [7:0] file_q[$];
  logic [7:0] prev_file[$];

  container_crc32_field_zeroed_check i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  crc32_zero_field_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending_results(pending_results),
    .last_file_crc(last_file_crc)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("container_crc32_field_zeroed_check test failed");
      $finish;
    end
  end

  // result-side stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready = 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tlast = l;
    do @(posedge clk); while (s_tready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) begin
      send_byte(file_q[i], i == file_q.size() - 1);
    end
    prev_file = file_q;
  endtask

  function automatic void build_file(input int len);
    file_q.delete();
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       file_q.push_back(8'h00);
        1:       file_q.push_back(8'hFF);
        default: file_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'(int'(idx) * 4);
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  initial begin
    int          len;
    int          kind;
    int          phase;
    logic [31:0] setting;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single-byte files, check skipped
    file_q = '{8'h00};
    send_file();
    file_q = '{8'hFF};
    send_file();
    // expected set to the last CRC, then an ignored write to the unused index
    wait_idle();
    apb_write(REG_EXPECTED_CRC, last_file_crc);
    file_q = '{8'hFF};
    send_file();
    wait_idle();
    apb_write(REG_NONE, 32'h0);
    // runs past the position limit, field bytes nonzero
    file_q.delete();
    repeat (18) file_q.push_back(8'hFF);
    send_file();
    file_q = '{8'h80, 8'h01, 8'h7F};
    send_file();
    wait_idle();
    apb_write(REG_EXPECTED_CRC, 32'hFFFF_FFFF);
    file_q = '{8'hA5, 8'h5A};
    send_file();

    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
      wait_idle();
      kind = (phase < 4) ? (3 - phase) : $urandom_range(0, 3);
      case (kind)
        0:       setting = 32'h0;
        1:       setting = 32'hFFFF_FFFF;
        2:       setting = $urandom();
        default: setting = last_file_crc;
      endcase
      apb_write(REG_EXPECTED_CRC, setting);
      if ($urandom_range(0, 2) == 0) apb_write(REG_NONE, $urandom());
      if (kind == 3) begin
        // same file with a different stored-CRC field must still match
        file_q = prev_file;
        for (int i = CRC_FIELD_OFFSET;
             i < CRC_FIELD_OFFSET + CRC_FIELD_LEN && i < file_q.size(); i++) begin
          file_q[i] = 8'($urandom_range(0, 255));
        end
        send_file();
      end
      repeat ($urandom_range(3, 10)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: len = $urandom_range(1, 16);
          6, 7, 8:          len = $urandom_range(12, 24);
          default:          len = $urandom_range(25, 48);
        endcase
        build_file(len);
        send_file();
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("container_crc32_field_zeroed_check test passed");
    end else begin
      $display("container_crc32_field_zeroed_check test failed");
    end
    $finish;
  end

endmodule
